>>> rtl/icm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icm_pkg: shared types and constants of the Ising Metropolis block
// Holds field widths, command and register codes, state types and the
// request and response structs of the acceptance unit.
// ----------------------------------------------------------------------------
package icm_pkg;

  // Lattice storage geometry.
  localparam int RowW     = 8;
  localparam int ColW     = 8;
  localparam int AddrW    = RowW + ColW;
  localparam int MaxRows  = 256;
  localparam int MaxCols  = 256;

  // Stream and configuration port widths.
  localparam int InDataW  = 24;
  localparam int InUserW  = 2;
  localparam int OutDataW = 40;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;

  // Result field widths.
  localparam int MagW     = 18;
  localparam int FlipW    = 17;

  // Energy and acceptance datapath widths.
  localparam int DeW      = 20;             // signed energy change
  localparam int DivW     = DeW - 1 + 16;   // dE << 16 dividend, dE non-negative
  localparam int SqSteps  = 16;
  localparam int RandW    = 24;

  // Generator constants.
  localparam logic [31:0] RngY0 = 32'd362436069;
  localparam logic [31:0] RngZ0 = 32'd521288629;
  localparam logic [31:0] RngW0 = 32'd88675123;

  // Quotient at or above this value gives a zero flip probability.
  localparam logic [DivW-1:0] ExpLimit = DivW'(17 << 16);

  // Input item kinds.
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_SWEEP = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgAddrW-1:0] CFG_ROWS     = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_COLS     = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_TEMP     = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_COUPLING = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_FIELD    = 3'd4;
  localparam logic [CfgAddrW-1:0] CFG_SEED     = 3'd5;

  // Main sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RSPIN,
    ST_RSPIN2,
    ST_FETCH,
    ST_ENERGY,
    ST_EVAL,
    ST_WAIT,
    ST_FLIP,
    ST_NEXT,
    ST_SUM,
    ST_SUMEND,
    ST_DONE
  } state_t;

  // Acceptance unit states.
  typedef enum logic [2:0] {
    AC_IDLE,
    AC_DIV,
    AC_CHK,
    AC_SQ,
    AC_CMP
  } acc_state_t;

  typedef struct packed {
    logic             start;
    logic [DeW-2:0]   de;
    logic [RandW-1:0] u;
  } acc_req_t;

  typedef struct packed {
    logic done;
    logic flip;
  } acc_rsp_t;

endpackage

>>> rtl/icm_accept.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icm_accept: Metropolis acceptance test for a non-negative energy change
// Divides dE << 16 by T one quotient bit a cycle, then raises
// (1 - x/2^16) to the power 2^16 by sixteen registered squarings and
// compares the result with the 24-bit random value.
// ----------------------------------------------------------------------------
module icm_accept (
  input  logic             clk,
  input  logic             rst_n,
  input  icm_pkg::acc_req_t acc_req,
  input  logic [15:0]      tq,
  output icm_pkg::acc_rsp_t acc_rsp
);
  import icm_pkg::*;

  acc_state_t state_r, state_nxt;

  logic [DivW-1:0]  quo_r;
  logic [16:0]      rem_r;
  logic [5:0]       cnt_r;
  logic [RandW-1:0] u_r;
  logic [31:0]      a_r;
  logic             done_r;
  logic             flip_r;

  logic [16:0]      trial;
  logic             fits;
  logic [63:0]      sq;

  // One restoring division step.
  assign trial = {rem_r[15:0], quo_r[DivW-1]};
  assign fits  = (trial >= {1'b0, tq});
  assign sq    = 64'(a_r) * 64'(a_r);

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AC_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      AC_IDLE: begin
        if (acc_req.start) state_nxt = AC_DIV;
      end
      AC_DIV: begin
        if (cnt_r == 6'(DivW - 1)) state_nxt = AC_CHK;
      end
      AC_CHK: begin
        if ((quo_r == '0) || (quo_r >= ExpLimit)) begin
          state_nxt = AC_IDLE;
        end else begin
          state_nxt = AC_SQ;
        end
      end
      AC_SQ: begin
        if (cnt_r == 6'(SqSteps - 1)) state_nxt = AC_CMP;
      end
      AC_CMP: state_nxt = AC_IDLE;
      default: state_nxt = AC_IDLE;
    endcase
  end

  // Done is a single-cycle pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= (state_r == AC_CMP) ||
                ((state_r == AC_CHK) && ((quo_r == '0) || (quo_r >= ExpLimit)));
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state_r)
      AC_IDLE: begin
        quo_r <= {acc_req.de, 16'd0};
        rem_r <= '0;
        cnt_r <= '0;
        u_r   <= acc_req.u;
      end
      AC_DIV: begin
        rem_r <= fits ? (trial - {1'b0, tq}) : trial;
        quo_r <= {quo_r[DivW-2:0], fits};
        cnt_r <= cnt_r + 6'd1;
      end
      AC_CHK: begin
        cnt_r  <= '0;
        a_r    <= 32'(33'h1_0000_0000 - 33'(quo_r));
        flip_r <= (quo_r == '0);
      end
      AC_SQ: begin
        a_r   <= sq[63:32];
        cnt_r <= cnt_r + 6'd1;
      end
      AC_CMP: begin
        flip_r <= (u_r < a_r[31:8]);
      end
      default: begin
      end
    endcase
  end

  assign acc_rsp.done = done_r;
  assign acc_rsp.flip = flip_r;

endmodule

>>> rtl/ising_checkerboard_metropolis_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising_checkerboard_metropolis_top: Ising lattice with Metropolis sweeps
// Holds a 256 x 256 spin lattice in block memory and one xorshift128
// generator; writes, reads and full checkerboard sweeps.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: in_tuser carries the kind (write, sweep, read); in_tdata
//   carries row, column and the spin to write. Each input transfer yields
//   exactly one result transfer with the spin read, the magnetization of
//   the latest sweep and the flips of this sweep.
//   A write yields its result directly; a read first fetches the spin from memory.
//   A sweep visits each in-use site once, in one of two color passes; a
//   site with dE < 0 flips without the acceptance unit, else the unit
//   runs (bit-serial divider plus 16 registered squarings).
//   The site cost is set by the single memory read port (five reads per
//   site) and by the acceptance unit. A recount pass then reads every
//   in-use site once, one per cycle.
//   One item is processed at a time; the next is taken once the result is
//   in the output register, so a stalled receiver holds off at most one
//   further item. Synchronous reset clears the control state, loads the
//   default registers and reseeds the generator; lattice contents are
//   undefined until written. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module ising_checkerboard_metropolis_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [icm_pkg::InDataW-1:0]    in_tdata,   // row[7:0], col[15:8], spin_in[16]
  input  logic [icm_pkg::InUserW-1:0]    in_tuser,   // kind[1:0]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [icm_pkg::OutDataW-1:0]   out_tdata,  // spin_out[0], magnetization_sum[18:1],
                                                     // flip_count[35:19]
  input  logic                           cfg_we,
  input  logic [icm_pkg::CfgAddrW-1:0]   cfg_addr,
  input  logic [icm_pkg::CfgDataW-1:0]   cfg_wdata
);
  import icm_pkg::*;

  // Configuration registers.
  logic [8:0]         rows_r;
  logic [8:0]         cols_r;
  logic [15:0]        temp_r;
  logic signed [15:0] coupling_r;
  logic signed [15:0] field_r;

  // Generator words.
  logic [31:0] rx_r, ry_r, rz_r, rw_r;
  logic [31:0] rng_t, rng_w_new;
  logic        rng_adv;

  // Sequencer.
  state_t state_r, state_nxt;
  logic        in_xfer;
  logic        color_r;
  logic [7:0]  i_r;
  logic [8:0]  j_r;
  logic [2:0]  fcnt_r;
  logic [2:0]  ones_r;
  logic        s_r;
  logic signed [DeW-1:0] de_r;
  logic [FlipW-1:0] flips_r;
  logic [AddrW-1:0] addr_r;

  // Recount.
  logic              sum_vld_r;
  logic signed [MagW-1:0] acc_r;
  logic signed [MagW-1:0] acc_add;
  logic signed [MagW-1:0] last_mag_r;

  // Result staging and output register.
  logic             res_spin_r;
  logic [FlipW-1:0] res_flips_r;
  logic             out_valid_r;
  logic             out_spin_r;
  logic [MagW-1:0]  out_mag_r;
  logic [FlipW-1:0] out_flips_r;
  logic             out_load;

  // Spin memory.
  logic             spin_mem [0:(1 << AddrW)-1];
  logic [AddrW-1:0] mem_raddr;
  logic [AddrW-1:0] mem_waddr;
  logic             mem_we;
  logic             mem_wdata;
  logic             rd_r;

  // Effective lattice size and periodic neighbors.
  logic [8:0] rows_eff, cols_eff;
  logic [7:0] rmax, cmax;
  logic [7:0] up, dn, lf, rt;
  logic [7:0] jc;
  logic [8:0] j_step;
  logic [7:0] i_inc;

  // Energy.
  logic signed [4:0]     nsum;
  logic signed [DeW-1:0] prod, bsum, b2, de_c;

  acc_req_t acc_req;
  acc_rsp_t acc_rsp;

  // Size clamping to [2, max].
  always_comb begin
    if (rows_r < 9'd2)                rows_eff = 9'd2;
    else if (rows_r > 9'(MaxRows))    rows_eff = 9'(MaxRows);
    else                              rows_eff = rows_r;
    if (cols_r < 9'd2)                cols_eff = 9'd2;
    else if (cols_r > 9'(MaxCols))    cols_eff = 9'(MaxCols);
    else                              cols_eff = cols_r;
  end

  assign rmax   = 8'(rows_eff - 9'd1);
  assign cmax   = 8'(cols_eff - 9'd1);
  assign jc     = j_r[7:0];
  assign up     = (i_r == 8'd0) ? rmax : i_r - 8'd1;
  assign dn     = (i_r == rmax) ? 8'd0 : i_r + 8'd1;
  assign lf     = (jc == 8'd0) ? cmax : jc - 8'd1;
  assign rt     = (jc == cmax) ? 8'd0 : jc + 8'd1;
  assign j_step = j_r + 9'd2;
  assign i_inc  = i_r + 8'd1;

  // Energy change: dE = 2 s (J nsum + h).
  assign nsum = $signed({1'b0, ones_r, 1'b0}) - 5'sd4;
  assign prod = DeW'(coupling_r) * DeW'(nsum);
  assign bsum = prod + DeW'(field_r);
  assign b2   = bsum <<< 1;
  assign de_c = s_r ? b2 : -b2;

  // xorshift128 step.
  assign rng_t     = rx_r ^ (rx_r << 11);
  assign rng_w_new = (rw_r ^ (rw_r >> 19)) ^ (rng_t ^ (rng_t >> 8));
  assign rng_adv   = (state_r == ST_EVAL) && !de_r[DeW-1];

  assign acc_req.start = rng_adv;
  assign acc_req.de    = de_r[DeW-2:0];
  assign acc_req.u     = rng_w_new[RandW-1:0];

  icm_accept u_accept (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc_req (acc_req),
    .tq      ((temp_r == 16'd0) ? 16'd1 : temp_r),
    .acc_rsp (acc_rsp)
  );

  // Handshakes; no transfer is taken while reset is held.
  assign in_tready = rst_n && (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r     <= 9'(MaxRows);
      cols_r     <= 9'(MaxCols);
      temp_r     <= 16'd4096;
      coupling_r <= 16'sd4096;
      field_r    <= 16'sd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ROWS:     rows_r     <= cfg_wdata[8:0];
        CFG_COLS:     cols_r     <= cfg_wdata[8:0];
        CFG_TEMP:     temp_r     <= cfg_wdata[15:0];
        CFG_COUPLING: coupling_r <= cfg_wdata[15:0];
        CFG_FIELD:    field_r    <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Generator: reload on reset or seed write, advance on each draw.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_r <= 32'd1;
      ry_r <= RngY0;
      rz_r <= RngZ0;
      rw_r <= RngW0;
    end else if (cfg_we && (cfg_addr == CFG_SEED)) begin
      rx_r <= cfg_wdata;
      ry_r <= RngY0;
      rz_r <= RngZ0;
      rw_r <= RngW0;
    end else if (rng_adv) begin
      rx_r <= ry_r;
      ry_r <= rz_r;
      rz_r <= rw_r;
      rw_r <= rng_w_new;
    end
  end

  // Memory read address and write port.
  always_comb begin
    mem_raddr = {i_r, jc};
    case (state_r)
      ST_RSPIN: mem_raddr = addr_r;
      ST_FETCH: begin
        case (fcnt_r)
          3'd1:    mem_raddr = {up, jc};
          3'd2:    mem_raddr = {dn, jc};
          3'd3:    mem_raddr = {i_r, lf};
          3'd4:    mem_raddr = {i_r, rt};
          default: mem_raddr = {i_r, jc};
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {i_r, jc};
    mem_wdata = !s_r;
    if (in_xfer && (in_tuser == KIND_WRITE)) begin
      mem_we    = 1'b1;
      mem_waddr = {in_tdata[7:0], in_tdata[15:8]};
      mem_wdata = in_tdata[16];
    end else if (state_r == ST_FLIP) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) spin_mem[mem_waddr] <= mem_wdata;
    rd_r <= spin_mem[mem_raddr];
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_tuser)
            KIND_SWEEP: state_nxt = ST_FETCH;
            KIND_READ:  state_nxt = ST_RSPIN;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_RSPIN:  state_nxt = ST_RSPIN2;
      ST_RSPIN2: state_nxt = ST_DONE;
      ST_FETCH: begin
        if (fcnt_r == 3'd5) state_nxt = ST_ENERGY;
      end
      ST_ENERGY: state_nxt = ST_EVAL;
      ST_EVAL:   state_nxt = de_r[DeW-1] ? ST_FLIP : ST_WAIT;
      ST_WAIT: begin
        if (acc_rsp.done) state_nxt = acc_rsp.flip ? ST_FLIP : ST_NEXT;
      end
      ST_FLIP:   state_nxt = ST_NEXT;
      ST_NEXT: begin
        if ((j_step < cols_eff) || (i_r != rmax) || !color_r) begin
          state_nxt = ST_FETCH;
        end else begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if ((i_r == rmax) && (jc == cmax)) state_nxt = ST_SUMEND;
      end
      ST_SUMEND: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Recount accumulation takes the memory read data in the cycle after the read.
  assign acc_add = acc_r + (rd_r ? 18'sd1 : -18'sd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r  <= 1'b0;
      last_mag_r <= '0;
    end else begin
      sum_vld_r <= (state_r == ST_SUM);
      if (state_r == ST_SUMEND) last_mag_r <= acc_add;
    end
  end

  // Sweep position, site fetch and result staging.
  always_ff @(posedge clk) begin
    if (sum_vld_r) acc_r <= acc_add;
    case (state_r)
      ST_IDLE: begin
        addr_r      <= {in_tdata[7:0], in_tdata[15:8]};
        color_r     <= 1'b0;
        i_r         <= 8'd0;
        j_r         <= 9'd0;
        fcnt_r      <= 3'd0;
        ones_r      <= 3'd0;
        flips_r     <= '0;
        res_spin_r  <= 1'b0;
        res_flips_r <= '0;
      end
      ST_RSPIN2: res_spin_r <= rd_r;
      ST_FETCH: begin
        fcnt_r <= fcnt_r + 3'd1;
        if (fcnt_r == 3'd1) s_r <= rd_r;
        else if (fcnt_r != 3'd0) ones_r <= ones_r + {2'd0, rd_r};
      end
      ST_ENERGY: de_r <= de_c;
      ST_FLIP:   flips_r <= flips_r + 17'd1;
      ST_NEXT: begin
        fcnt_r <= 3'd0;
        ones_r <= 3'd0;
        if (j_step < cols_eff) begin
          j_r <= j_step;
        end else if (i_r != rmax) begin
          i_r <= i_inc;
          j_r <= {8'd0, (i_inc[0] != color_r)};
        end else if (!color_r) begin
          color_r <= 1'b1;
          i_r     <= 8'd0;
          j_r     <= 9'd1;
        end else begin
          i_r   <= 8'd0;
          j_r   <= 9'd0;
          acc_r <= '0;
        end
      end
      ST_SUM: begin
        if (jc == cmax) begin
          j_r <= 9'd0;
          i_r <= i_inc;
        end else begin
          j_r <= j_r + 9'd1;
        end
      end
      ST_SUMEND: res_flips_r <= flips_r;
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_spin_r  <= res_spin_r;
      out_mag_r   <= last_mag_r;
      out_flips_r <= res_flips_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_flips_r, out_mag_r, out_spin_r};

endmodule

>>> rtl/icm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icm_checker: port-level checks of the Ising Metropolis block
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module icm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [icm_pkg::OutDataW-1:0] out_tdata
);

  // A stalled result holds its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result payload changed while stalled");

  // No result is presented right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A read result that returns spin 1 never reports flips.
  a_read_no_flips: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> (out_tdata[35:19] == 17'd0))
    else $error("spin read with nonzero flip count");

  // An input transfer leaves the block busy for the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item taken without a gap");

endmodule

bind ising_checkerboard_metropolis_top icm_checker u_icm_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Ising Metropolis lattice block
// Drives spin writes, reads and checkerboard sweeps over the input stream
// under random bursts and output stalls. A scoreboard keeps its own lattice,
// generator and registers, predicts every result and compares each field.
// ----------------------------------------------------------------------------
module tb_top;
  import icm_pkg::*;

  localparam logic [1:0] KindSpare = 2'd3;

  // One predicted result.
  typedef struct {
    bit               spin;
    logic signed [17:0] mag;
    bit [16:0]        flips;
  } lattice_result_t;

  // Scoreboard: lattice predictor plus the queue of expected results.
  class lattice_scoreboard;
    bit                 lattice[65536];
    bit [8:0]           rows, cols;
    bit [15:0]          temp;
    int                 coupling_j, field_h;
    bit [31:0]          gen[4];
    logic signed [17:0] held_mag;
    lattice_result_t    pending_q[$];
    int                 errors;

    function void init();
      rows = 256; cols = 256; temp = 4096; coupling_j = 4096; field_h = 0;
      reseed(32'd1);
      held_mag = '0;
      errors = 0;
    endfunction

    function void reseed(bit [31:0] s);
      gen[0] = s; gen[1] = RngY0; gen[2] = RngZ0; gen[3] = RngW0;
    endfunction

    function void write_reg(logic [CfgAddrW-1:0] idx, bit [31:0] v);
      case (idx)
        CFG_ROWS:     rows = v[8:0];
        CFG_COLS:     cols = v[8:0];
        CFG_TEMP:     temp = v[15:0];
        CFG_COUPLING: coupling_j = int'($signed(v[15:0]));
        CFG_FIELD:    field_h = int'($signed(v[15:0]));
        CFG_SEED:     reseed(v);
        default: ;
      endcase
    endfunction

    function bit [31:0] draw();
      bit [31:0] t, w;
      t = gen[0] ^ (gen[0] << 11);
      w = gen[3];
      gen[0] = gen[1]; gen[1] = gen[2]; gen[2] = w;
      gen[3] = (w ^ (w >> 19)) ^ (t ^ (t >> 8));
      return gen[3];
    endfunction

    // Metropolis acceptance with the fixed-point exp approximation.
    function bit accept(int de);
      bit [63:0] u, tq, q, a, p;
      if (de < 0) return 1'b1;
      u  = 64'(draw() & 32'h00FF_FFFF);
      tq = (temp != 0) ? {48'd0, temp} : 64'd1;
      q  = ({32'd0, de[31:0]} << 16) / tq;
      if (q == 0) p = 64'd1 << 24;
      else if (q >= (64'd17 << 16)) p = 0;
      else begin
        a = (64'd1 << 32) - q;
        for (int k = 0; k < 16; k++) a = (a * a) >> 32;
        p = a >> 8;
      end
      return u < p;
    endfunction

    function int spin_val(int r, int c);
      return lattice[r * 256 + c] ? 1 : -1;
    endfunction

    // One checkerboard sweep followed by the recount.
    function bit [16:0] sweep();
      int rr, cc, up, dn, lf, rt, s, nsum, de, sum;
      bit [16:0] flips;
      rr = (rows < 2) ? 2 : (rows > 256) ? 256 : rows;
      cc = (cols < 2) ? 2 : (cols > 256) ? 256 : cols;
      flips = 0;
      for (int color = 0; color < 2; color++) begin
        for (int i = 0; i < rr; i++) begin
          up = (i == 0) ? rr - 1 : i - 1;
          dn = (i == rr - 1) ? 0 : i + 1;
          for (int j = ((i & 1) == color) ? 0 : 1; j < cc; j += 2) begin
            lf = (j == 0) ? cc - 1 : j - 1;
            rt = (j == cc - 1) ? 0 : j + 1;
            s = spin_val(i, j);
            nsum = spin_val(up, j) + spin_val(dn, j) + spin_val(i, lf) + spin_val(i, rt);
            de = 2 * s * (coupling_j * nsum + field_h);
            if (accept(de)) begin
              lattice[i * 256 + j] = ~lattice[i * 256 + j];
              flips++;
            end
          end
        end
      end
      sum = 0;
      for (int i = 0; i < rr; i++)
        for (int j = 0; j < cc; j++)
          sum += spin_val(i, j);
      held_mag = sum[17:0];
      return flips;
    endfunction

    // Note an accepted input transfer and queue its expected result.
    function void note_input(logic [1:0] kind, bit [7:0] r, bit [7:0] c, bit s);
      lattice_result_t res;
      res.spin = 0;
      res.flips = 0;
      case (kind)
        KIND_WRITE: lattice[{r, 8'd0} + c] = s;
        KIND_SWEEP: res.flips = sweep();
        KIND_READ:  res.spin = lattice[{r, 8'd0} + c];
        default: ;
      endcase
      res.mag = held_mag;
      pending_q.push_back(res);
    endfunction

    // Check one result transfer against the oldest expectation.
    function void check_result(logic [OutDataW-1:0] d);
      lattice_result_t res;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, d);
        errors++;
        return;
      end
      res = pending_q.pop_front();
      if (d[0] !== res.spin) begin
        $display("%0t: spin_out expected %0d actual %0d", $time, res.spin, d[0]);
        errors++;
      end
      if (d[18:1] !== res.mag) begin
        $display("%0t: magnetization expected %0d actual %0d", $time, res.mag,
                 $signed(d[18:1]));
        errors++;
      end
      if (d[35:19] !== res.flips) begin
        $display("%0t: flip_count expected %0d actual %0d", $time, res.flips, d[35:19]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [InDataW-1:0] in_tdata = '0;
  logic [InUserW-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OutDataW-1:0] out_tdata;
  logic cfg_we = 0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  lattice_scoreboard sb = new();
  int burst_left = 0;

  ising_checkerboard_metropolis_top i_dut (.*);

  always #1 clk = ~clk;

  // Result side: the stall pattern periodically switches to a randomly chosen mode.
  int stall_mode = 0;
  int stall_cnt = 0;
  always @(negedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Send one item; the sender keeps tvalid high within a burst.
  task automatic send_item(logic [1:0] kind, int r, int c, bit s);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = {7'd0, s, c[7:0], r[7:0]};
    do @(posedge clk); while (!in_tready);
    sb.note_input(kind, r[7:0], c[7:0], s);
    if (burst_left == 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  // Hold off the sender until every expected result has come back.
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgAddrW-1:0] idx, bit [31:0] v);
    @(negedge clk);
    cfg_we = 1'b1; cfg_addr = idx; cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, v);
  endtask

  // Fill the in-use lattice, then run random operations on it.
  task automatic run_phase(int n_ops);
    int rr, cc, pick;
    rr = (sb.rows < 2) ? 2 : (sb.rows > 256) ? 256 : sb.rows;
    cc = (sb.cols < 2) ? 2 : (sb.cols > 256) ? 256 : sb.cols;
    for (int i = 0; i < rr; i++)
      for (int j = 0; j < cc; j++)
        send_item(KIND_WRITE, i, j, $urandom_range(0, 1));
    for (int k = 0; k < n_ops; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) send_item(KIND_SWEEP, $urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 1));
      else if (pick < 45) send_item(KIND_WRITE, $urandom_range(0, rr - 1),
                                    $urandom_range(0, cc - 1), $urandom_range(0, 1));
      else if (pick < 55) send_item(KIND_WRITE, $urandom_range(0, 255),
                                    $urandom_range(0, 255), $urandom_range(0, 1));
      else if (pick < 90) send_item(KIND_READ, $urandom_range(0, rr - 1),
                                    $urandom_range(0, cc - 1), $urandom_range(0, 1));
      else send_item(KindSpare, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 1));
    end
    drain();
  endtask

  task automatic random_config();
    write_reg(CFG_ROWS, $urandom_range(2, 4));
    write_reg(CFG_COLS, $urandom_range(2, 4));
    write_reg(CFG_TEMP, $urandom_range(1, 65535));
    write_reg(CFG_COUPLING, $urandom_range(0, 1) ? $urandom_range(0, 16383) - 8192
                                                 : $urandom);
    write_reg(CFG_FIELD, $urandom_range(0, 1) ? $urandom_range(0, 8191) - 4096 : $urandom);
    write_reg(CFG_SEED, $urandom);
  endtask

  initial begin
    sb.init();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: corner and inner sites, reads back, the unused kind, magnetization still zero.
    send_item(KIND_WRITE, 0, 0, 1'b1);
    send_item(KIND_WRITE, 255, 255, 1'b0);
    send_item(KIND_WRITE, 170, 85, 1'b1);
    send_item(KIND_WRITE, 85, 170, 1'b0);
    send_item(KIND_READ, 0, 0, 1'b0);
    send_item(KIND_READ, 255, 255, 1'b1);
    send_item(KIND_READ, 170, 85, 1'b0);
    send_item(KIND_READ, 85, 170, 1'b1);
    send_item(KindSpare, 255, 255, 1'b1);
    drain();

    // Smallest lattice (size below range saturates), strongest coupling, field at minimum.
    write_reg(CFG_ROWS, 0);
    write_reg(CFG_COLS, 2);
    write_reg(CFG_TEMP, 1);
    write_reg(CFG_COUPLING, 32'h0000_7FFF);
    write_reg(CFG_FIELD, 32'h0000_8000);
    write_reg(CFG_SEED, 32'hFFFF_FFFF);
    send_item(KIND_WRITE, 0, 0, 1'b1);
    send_item(KIND_WRITE, 0, 1, 1'b1);
    send_item(KIND_WRITE, 1, 0, 1'b0);
    send_item(KIND_WRITE, 1, 1, 1'b1);
    send_item(KIND_SWEEP, 0, 0, 1'b0);
    send_item(KIND_READ, 1, 0, 1'b0);
    send_item(KIND_READ, 255, 255, 1'b0);
    send_item(KindSpare, 0, 0, 1'b0);
    drain();

    // Odd height; hottest, most negative coupling, largest field, zero seed.
    write_reg(CFG_ROWS, 3);
    write_reg(CFG_COLS, 2);
    write_reg(CFG_TEMP, 65535);
    write_reg(CFG_COUPLING, 32'h0000_8000);
    write_reg(CFG_FIELD, 32'h0000_7FFF);
    write_reg(CFG_SEED, 0);
    run_phase(4);

    // Zero temperature behaves as the smallest one; odd width on the columns.
    write_reg(CFG_ROWS, 2);
    write_reg(CFG_COLS, 5);
    write_reg(CFG_TEMP, 0);
    write_reg(CFG_COUPLING, 32'h0000_1000);
    write_reg(CFG_FIELD, 0);
    run_phase(6);

    // Random settings on small lattices.
    for (int ph = 0; ph < 3; ph++) begin
      random_config();
      run_phase(12);
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> ising_checkerboard_metropolis_top.f
rtl/icm_pkg.sv
rtl/icm_accept.sv
rtl/ising_checkerboard_metropolis_top.sv
rtl/icm_checker.sv
tb/tb_top.sv
